/* hdl/look_elevator_controller_core_defines.svh */
// ----------------------------------------------------------------------------
// look elevator controller assertion macros
// shared assertion forms for the rtl
// ----------------------------------------------------------------------------
`ifndef LOOK_ELEVATOR_CONTROLLER_CORE_DEFINES_SVH
`define LOOK_ELEVATOR_CONTROLLER_CORE_DEFINES_SVH

// implication checked every clock outside reset
`define LEC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication outside reset
`define LEC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* hdl/lec_pkg.sv */
// ----------------------------------------------------------------------------
// lec_pkg
// types, constants and codes of the look elevator controller
// ----------------------------------------------------------------------------
package lec_pkg;

    localparam int FLOORS_DEF      = 5;
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int CAR_SLOTS_DEF   = 5;

    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_RIDE  = 2'd1,
        KIND_START = 2'd2,
        KIND_STOP  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        MODE_OFFLINE = 3'd0,
        MODE_IDLE    = 3'd1,
        MODE_UP      = 3'd2,
        MODE_DOWN    = 3'd3,
        MODE_LOADING = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        DELAY_NONE = 2'd0,
        DELAY_LOAD = 2'd1,
        DELAY_MOVE = 2'd2
    } delay_t;

    typedef enum logic [2:0] {
        CFG_MAX_RIDERS = 3'd0,
        CFG_MAX_WEIGHT = 3'd1,
        CFG_WEIGHT0    = 3'd2,
        CFG_WEIGHT1    = 3'd3,
        CFG_WEIGHT2    = 3'd4,
        CFG_WEIGHT3    = 3'd5
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_RIDE_WR,
        ST_SCAN,
        ST_TICK_DECIDE,
        ST_UNLOAD,
        ST_BOARD_RD,
        ST_BOARD_WAIT,
        ST_BOARD_CHK,
        ST_WORK_SCAN,
        ST_MOVE,
        ST_SUM,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] start_floor;
        logic [2:0] target_floor;
        logic [2:0] rider_type;
    } in_word_t;

    typedef struct packed {
        logic        status;
        logic [2:0]  car_state;
        logic [2:0]  floor_now;
        logic [7:0]  load_weight;
        logic [2:0]  riders_on_board;
        logic [6:0]  queued_riders;
        logic [31:0] total_served;
        logic [1:0]  delay_code;
    } out_word_t;

endpackage

/* hdl/lec_ram.sv */
// ----------------------------------------------------------------------------
// lec_ram
// generic single port write, single port registered read memory
// ----------------------------------------------------------------------------
module lec_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* hdl/look_elevator_controller_core.sv */
// ----------------------------------------------------------------------------
// look_elevator_controller_core
// elevator car controller with look scheduling and per-floor rider queues
// ----------------------------------------------------------------------------
// channel   direction  handshake               word
// in        input      start high, busy low    in_word_t
// cfg       input      cfg_valid and cfg_ready index and data
// result    output     result_valid one cycle  out_word_t
//
// busy time per word is set by the one floor scan unit and the queue memory
// read latency
// the result strobe comes in the first idle cycle after busy
// reset is asynchronous and clears all control state; queue entries are
// undefined until written and are never used before
// the result cannot be stalled
// ----------------------------------------------------------------------------
module look_elevator_controller_core
    import lec_pkg::*;
#(
    parameter int FLOORS      = FLOORS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int CAR_SLOTS   = CAR_SLOTS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  in_word_t  in_word,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data,
    output logic      result_valid,
    output out_word_t result
);
`include "look_elevator_controller_core_defines.svh"

    localparam int FW = 3;
    localparam int QAW = $clog2(QUEUE_DEPTH);
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);
    localparam int MAW = $clog2(FLOORS * QUEUE_DEPTH);
    localparam int SW = (CAR_SLOTS > 1) ? $clog2(CAR_SLOTS) : 1;
    localparam int SCW = $clog2(CAR_SLOTS + 1);
    localparam int FIW = (FLOORS > 1) ? $clog2(FLOORS) : 1;

    // configuration
    logic [2:0] max_riders_reg;
    logic [7:0] max_weight_reg;
    logic [5:0] weight_reg [4];

    // car and queue state
    logic [QAW-1:0] head_reg  [FLOORS];
    logic [QCW-1:0] count_reg [FLOORS];
    logic           slot_v_reg [CAR_SLOTS];
    logic [1:0]     slot_t_reg [CAR_SLOTS];
    logic [2:0]     slot_d_reg [CAR_SLOTS];
    mode_t          mode_reg;
    logic [FW-1:0]  floor_reg;
    logic           up_reg, stopping_reg;
    logic [7:0]     weight_sum_reg;
    logic [31:0]    served_reg;

    state_t         state_reg, state_next;
    in_word_t       in_reg;
    logic           status_reg;
    delay_t         delay_reg;
    logic [FIW-1:0] idx_reg;       // floor index for scans
    logic [SW-1:0]  sidx_reg;      // slot index for unload scan
    logic           ahead_reg, behind_reg, drop_reg, pick_reg;
    logic [6:0]     wait_sum_reg;
    logic [SCW-1:0] riders_reg;
    logic [4:0]     entry_reg;

    // queue memory
    logic           ram_we;
    logic [MAW-1:0] ram_waddr, ram_raddr;
    logic [4:0]     ram_rdata;

    lec_ram #(.WIDTH(5), .DEPTH(FLOORS * QUEUE_DEPTH)) u_queue (
        .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata({in_reg.rider_type[1:0],
        in_reg.target_floor}), .raddr(ram_raddr), .rdata(ram_rdata)
    );

    logic [FIW-1:0] cur_fi, req_fi;
    assign cur_fi = FIW'(floor_reg - 3'd1);
    assign req_fi = FIW'(in_reg.start_floor - 3'd1);

    // queue address: floor*depth + pointer
    logic [QAW:0]   tail_sum;
    logic [QAW-1:0] tail_ptr;
    assign tail_sum  = (QAW + 1)'(head_reg[req_fi]) + (QAW + 1)'(count_reg[req_fi]);
    assign tail_ptr  = (32'(tail_sum) >= QUEUE_DEPTH) ? QAW'(32'(tail_sum) - QUEUE_DEPTH)
                                                      : QAW'(tail_sum);
    assign ram_we    = (state_reg == ST_RIDE_WR) && !status_reg;
    assign ram_waddr = MAW'(MAW'(req_fi) * MAW'(QUEUE_DEPTH) + MAW'(tail_ptr));
    assign ram_raddr = MAW'(MAW'(cur_fi) * MAW'(QUEUE_DEPTH) + MAW'(head_reg[cur_fi]));

    // rider bound for a floor, small or-reduction over slots
    function automatic logic bound_for(input logic [2:0] f,
                                       input logic v [CAR_SLOTS],
                                       input logic [2:0] d [CAR_SLOTS]);
        logic r;
        r = 1'b0;
        for (int i = 0; i < CAR_SLOTS; i++)
        begin
            if (v[i] && d[i] == f)
            begin
                r = 1'b1;
            end
        end
        return r;
    endfunction

    // first free slot
    logic [SW-1:0] free_slot;
    always_comb
    begin
        free_slot = '0;
        for (int i = CAR_SLOTS - 1; i >= 0; i--)
        begin
            if (!slot_v_reg[i])
            begin
                free_slot = SW'(i);
            end
        end
    end

    // shared floor-need unit at idx_reg
    logic [2:0] scan_floor;
    logic       scan_need;
    assign scan_floor = 3'(idx_reg) + 3'd1;
    assign scan_need  = (!stopping_reg && count_reg[idx_reg] != '0)
                        || bound_for(scan_floor, slot_v_reg, slot_d_reg);

    // board check
    logic [5:0] head_w;
    logic [8:0] board_sum;
    logic       head_fits;
    assign head_w    = weight_reg[entry_reg[4:3]];
    assign board_sum = 9'(weight_sum_reg) + 9'(head_w);
    assign head_fits = (count_reg[cur_fi] != '0)
                       && (32'(riders_reg) < 32'(max_riders_reg))
                       && (32'(riders_reg) < CAR_SLOTS)
                       && (board_sum <= 9'(max_weight_reg));

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:        if (start) state_next = ST_DECODE;
            ST_DECODE:
            begin
                case (in_reg.kind)
                    KIND_TICK:  state_next = ST_TICK_DECIDE;
                    KIND_RIDE:  state_next = ST_RIDE_WR;
                    default:    state_next = ST_SUM;
                endcase
            end
            ST_RIDE_WR:     state_next = ST_SUM;
            ST_TICK_DECIDE:
            begin
                if (mode_reg == MODE_OFFLINE || (stopping_reg && riders_reg == '0))
                    state_next = ST_SUM;
                else
                    state_next = ST_UNLOAD;
            end
            ST_UNLOAD:
            begin
                if (sidx_reg == SW'(CAR_SLOTS - 1)) state_next = ST_BOARD_RD;
            end
            ST_BOARD_RD:    state_next = ST_BOARD_WAIT;
            ST_BOARD_WAIT:  state_next = ST_BOARD_CHK;
            ST_BOARD_CHK:
            begin
                if (pick_reg && head_fits) state_next = ST_BOARD_RD;
                else if (drop_reg || pick_reg) state_next = ST_SUM;
                else state_next = ST_WORK_SCAN;
            end
            ST_WORK_SCAN:
            begin
                if (idx_reg == FIW'(FLOORS - 1)) state_next = ST_MOVE;
            end
            ST_MOVE:        state_next = ST_SUM;
            ST_SUM:
            begin
                if (idx_reg == FIW'(FLOORS - 1)) state_next = ST_DONE;
            end
            ST_DONE:        state_next = ST_IDLE;
            default:        state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_riders_reg <= 3'd5;
            max_weight_reg <= 8'd50;
            weight_reg[0]  <= 6'd3;
            weight_reg[1]  <= 6'd14;
            weight_reg[2]  <= 6'd10;
            weight_reg[3]  <= 6'd16;
            for (int f = 0; f < FLOORS; f++)
            begin
                head_reg[f]  <= '0;
                count_reg[f] <= '0;
            end
            for (int i = 0; i < CAR_SLOTS; i++)
            begin
                slot_v_reg[i] <= 1'b0;
            end
            mode_reg       <= MODE_OFFLINE;
            floor_reg      <= 3'd1;
            up_reg         <= 1'b1;
            stopping_reg   <= 1'b0;
            weight_sum_reg <= '0;
            served_reg     <= '0;
            result_valid   <= 1'b0;
            result         <= '0;
            riders_reg     <= '0;
            idx_reg        <= '0;
            sidx_reg       <= '0;
            status_reg     <= 1'b0;
            delay_reg      <= DELAY_NONE;
            drop_reg       <= 1'b0;
            pick_reg       <= 1'b0;
            ahead_reg      <= 1'b0;
            behind_reg     <= 1'b0;
            wait_sum_reg   <= '0;
        end
        else
        begin
            result_valid <= 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_MAX_RIDERS: max_riders_reg <= cfg_data[2:0];
                    CFG_MAX_WEIGHT: max_weight_reg <= cfg_data;
                    CFG_WEIGHT0:    weight_reg[0]  <= cfg_data[5:0];
                    CFG_WEIGHT1:    weight_reg[1]  <= cfg_data[5:0];
                    CFG_WEIGHT2:    weight_reg[2]  <= cfg_data[5:0];
                    CFG_WEIGHT3:    weight_reg[3]  <= cfg_data[5:0];
                    default: ;
                endcase
            end
            case (state_reg)
                ST_IDLE:
                begin
                    status_reg <= 1'b0;
                    delay_reg  <= DELAY_NONE;
                    idx_reg    <= '0;
                    sidx_reg   <= '0;
                    drop_reg   <= 1'b0;
                    pick_reg   <= 1'b0;
                    ahead_reg  <= 1'b0;
                    behind_reg <= 1'b0;
                    wait_sum_reg <= '0;
                end
                ST_DECODE:
                begin
                    case (in_reg.kind)
                        KIND_RIDE:
                        begin
                            if (in_reg.start_floor < 3'd1
                                || 32'(in_reg.start_floor) > FLOORS
                                || in_reg.target_floor < 3'd1
                                || 32'(in_reg.target_floor) > FLOORS
                                || in_reg.start_floor == in_reg.target_floor
                                || in_reg.rider_type > 3'd3)
                                status_reg <= 1'b1;
                            else if (32'(count_reg[req_fi]) >= QUEUE_DEPTH)
                                status_reg <= 1'b1;
                        end
                        KIND_START:
                        begin
                            if (mode_reg != MODE_OFFLINE)
                                status_reg <= 1'b1;
                            else
                            begin
                                floor_reg      <= 3'd1;
                                weight_sum_reg <= '0;
                                stopping_reg   <= 1'b0;
                                up_reg         <= 1'b1;
                                riders_reg     <= '0;
                                for (int i = 0; i < CAR_SLOTS; i++)
                                begin
                                    slot_v_reg[i] <= 1'b0;
                                end
                                mode_reg <= MODE_IDLE;
                            end
                        end
                        KIND_STOP:
                        begin
                            if (stopping_reg) status_reg <= 1'b1;
                            else stopping_reg <= 1'b1;
                        end
                        default: ;
                    endcase
                end
                ST_RIDE_WR:
                begin
                    if (!status_reg)
                        count_reg[req_fi] <= count_reg[req_fi] + QCW'(1);
                end
                ST_TICK_DECIDE:
                begin
                    entry_reg <= ram_rdata;
                    if (mode_reg != MODE_OFFLINE && stopping_reg && riders_reg == '0)
                        mode_reg <= MODE_OFFLINE;
                end
                ST_UNLOAD:
                begin
                    // boarding is decided on the car as it arrived
                    if (sidx_reg == '0)
                        pick_reg <= !stopping_reg && head_fits;
                    if (slot_v_reg[sidx_reg] && slot_d_reg[sidx_reg] == floor_reg)
                    begin
                        drop_reg <= 1'b1;
                        mode_reg <= MODE_LOADING;
                        delay_reg <= DELAY_LOAD;
                        slot_v_reg[sidx_reg] <= 1'b0;
                        riders_reg <= riders_reg - SCW'(1);
                        if (weight_sum_reg > 8'(weight_reg[slot_t_reg[sidx_reg]]))
                            weight_sum_reg <= weight_sum_reg
                                              - 8'(weight_reg[slot_t_reg[sidx_reg]]);
                        else
                            weight_sum_reg <= '0;
                        if (served_reg != 32'hFFFF_FFFF)
                            served_reg <= served_reg + 32'd1;
                    end
                    sidx_reg <= sidx_reg + SW'(1);
                end
                ST_BOARD_WAIT:
                begin
                    entry_reg <= ram_rdata;
                end
                ST_BOARD_CHK:
                begin
                    if (pick_reg && head_fits)
                    begin
                        mode_reg  <= MODE_LOADING;
                        delay_reg <= DELAY_LOAD;
                        slot_v_reg[free_slot] <= 1'b1;
                        slot_t_reg[free_slot] <= entry_reg[4:3];
                        slot_d_reg[free_slot] <= entry_reg[2:0];
                        riders_reg <= riders_reg + SCW'(1);
                        weight_sum_reg <= board_sum[7:0];
                        if (head_reg[cur_fi] == QAW'(QUEUE_DEPTH - 1))
                            head_reg[cur_fi] <= '0;
                        else
                            head_reg[cur_fi] <= head_reg[cur_fi] + QAW'(1);
                        count_reg[cur_fi] <= count_reg[cur_fi] - QCW'(1);
                    end
                    else if (!drop_reg && !pick_reg)
                    begin
                        idx_reg <= '0;
                    end
                end
                ST_WORK_SCAN:
                begin
                    if (scan_need && scan_floor > floor_reg)
                        ahead_reg <= 1'b1;
                    if (scan_need && scan_floor < floor_reg)
                        behind_reg <= 1'b1;
                    idx_reg <= idx_reg + FIW'(1);
                    if (idx_reg == FIW'(FLOORS - 1))
                        idx_reg <= '0;
                end
                ST_MOVE:
                begin
                    // ahead_reg: work above, behind_reg: work below
                    if ((up_reg && ahead_reg) || (!up_reg && !behind_reg && ahead_reg))
                    begin
                        up_reg    <= 1'b1;
                        mode_reg  <= MODE_UP;
                        floor_reg <= floor_reg + 3'd1;
                        delay_reg <= DELAY_MOVE;
                    end
                    else if (behind_reg)
                    begin
                        up_reg    <= 1'b0;
                        mode_reg  <= MODE_DOWN;
                        floor_reg <= floor_reg - 3'd1;
                        delay_reg <= DELAY_MOVE;
                    end
                    else
                    begin
                        mode_reg <= MODE_IDLE;
                    end
                end
                ST_SUM:
                begin
                    wait_sum_reg <= wait_sum_reg + 7'(count_reg[idx_reg]);
                    if (idx_reg != FIW'(FLOORS - 1))
                        idx_reg <= idx_reg + FIW'(1);
                end
                ST_DONE:
                begin
                    result_valid           <= 1'b1;
                    result.status          <= status_reg;
                    result.car_state       <= mode_reg;
                    result.floor_now       <= floor_reg;
                    result.load_weight     <= weight_sum_reg;
                    result.riders_on_board <= 3'(riders_reg);
                    result.queued_riders   <= wait_sum_reg;
                    result.total_served    <= served_reg;
                    result.delay_code      <= delay_reg;
                end
                default: ;
            endcase
        end
    end

    // input word capture
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            in_reg <= in_word;
        end
    end

    `LEC_ASSERT_IMPL(a_busy_result, clk, rst_n, result_valid, state_reg == ST_IDLE)
    `LEC_ASSERT_IMPL(a_floor_range, clk, rst_n, 1'b1,
                     floor_reg >= 3'd1 && 32'(floor_reg) <= FLOORS)
    `LEC_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
    `LEC_ASSERT_IMPL(a_riders_cap, clk, rst_n, 1'b1, 32'(riders_reg) <= CAR_SLOTS)

endmodule

/* tb/sv/lec_checker.sv */
// ----------------------------------------------------------------------------
// lec_checker
// watches the command, register and result channels of the elevator core,
// keeps its own copy of the scheduler state and compares every result word
// ----------------------------------------------------------------------------
module lec_checker
    import lec_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  logic      busy,
    input  in_word_t  in_word,
    input  logic      cfg_valid,
    input  logic      cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  logic      result_valid,
    input  out_word_t result,
    output int        fail_count,
    output int        pending,
    output int        tick_count,
    output int        move_count,
    output int        reject_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NF = FLOORS_DEF;
    localparam int QD = QUEUE_DEPTH_DEF;
    localparam int NS = CAR_SLOTS_DEF;

    int unsigned lim_riders;
    int unsigned lim_weight;
    int unsigned type_weight [4];
    logic [4:0]  queue_mem [NF][QD];
    int unsigned q_head [NF];
    int unsigned q_count [NF];
    logic [5:0]  slots [NS];
    mode_t       mode;
    int unsigned car_floor;
    bit          going_up;
    bit          stopping;
    int unsigned weight_sum;
    int unsigned served;
    out_word_t   expected_words [$];

    function automatic int unsigned riders_now();
        int unsigned n;
        n = 0;
        for (int i = 0; i < NS; i++)
            if (slots[i][5]) n++;
        return n;
    endfunction

    function automatic bit bound_for(int unsigned f);
        for (int i = 0; i < NS; i++)
            if (slots[i][5] && slots[i][2:0] == f) return 1;
        return 0;
    endfunction

    function automatic bit floor_needs(int unsigned f);
        return (!stopping && q_count[f-1] > 0) || bound_for(f);
    endfunction

    function automatic bit work_ahead(bit up);
        if (up) begin
            for (int f = car_floor + 1; f <= NF; f++)
                if (floor_needs(f)) return 1;
        end
        else begin
            for (int f = int'(car_floor) - 1; f >= 1; f--)
                if (floor_needs(f)) return 1;
        end
        return 0;
    endfunction

    function automatic bit head_fits();
        int unsigned fi;
        int unsigned n;
        logic [4:0] e;
        fi = car_floor - 1;
        if (q_count[fi] == 0) return 0;
        e = queue_mem[fi][q_head[fi]];
        n = riders_now();
        return n < lim_riders && n < NS && weight_sum + type_weight[e[4:3]] <= lim_weight;
    endfunction

    function automatic delay_t run_tick();
        bit drop;
        bit pick;
        bit up;
        bit work;
        int unsigned fi;
        int unsigned w;
        logic [4:0] e;
        if (mode == MODE_OFFLINE) return DELAY_NONE;
        if (stopping && riders_now() == 0) begin
            mode = MODE_OFFLINE;
            return DELAY_NONE;
        end
        drop = bound_for(car_floor);
        pick = !stopping && head_fits();
        if (drop || pick) begin
            mode = MODE_LOADING;
            for (int i = 0; i < NS; i++)
                if (slots[i][5] && slots[i][2:0] == car_floor) begin
                    w = type_weight[slots[i][4:3]];
                    weight_sum = weight_sum > w ? weight_sum - w : 0;
                    slots[i] = '0;
                    if (served != 32'hFFFF_FFFF) served++;
                end
            if (pick) begin
                fi = car_floor - 1;
                while (head_fits()) begin
                    e = queue_mem[fi][q_head[fi]];
                    for (int i = 0; i < NS; i++)
                        if (!slots[i][5]) begin
                            slots[i] = {1'b1, e};
                            break;
                        end
                    weight_sum += type_weight[e[4:3]];
                    q_head[fi] = (q_head[fi] + 1) % QD;
                    q_count[fi]--;
                end
            end
            return DELAY_LOAD;
        end
        work = 0;
        for (int f = 1; f <= NF; f++)
            if (floor_needs(f)) work = 1;
        if (work) begin
            up = going_up;
            if (!work_ahead(up)) begin
                if (!work_ahead(!up)) begin
                    mode = MODE_IDLE;
                    return DELAY_NONE;
                end
                up = !up;
            end
            going_up = up;
            mode = up ? MODE_UP : MODE_DOWN;
            car_floor = up ? car_floor + 1 : car_floor - 1;
            return DELAY_MOVE;
        end
        mode = MODE_IDLE;
        return DELAY_NONE;
    endfunction

    function automatic out_word_t predict_word(in_word_t w);
        out_word_t o;
        int unsigned sf;
        int unsigned df;
        int unsigned waiting;
        delay_t dly;
        sf = w.start_floor;
        df = w.target_floor;
        o = '0;
        dly = DELAY_NONE;
        case (kind_t'(w.kind))
            KIND_TICK: dly = run_tick();
            KIND_RIDE:
                if (sf < 1 || sf > NF || df < 1 || df > NF || sf == df || w.rider_type > 3
                    || q_count[sf-1] >= QD)
                    o.status = 1'b1;
                else begin
                    queue_mem[sf-1][(q_head[sf-1] + q_count[sf-1]) % QD] =
                        {w.rider_type[1:0], w.target_floor};
                    q_count[sf-1]++;
                end
            KIND_START:
                if (mode != MODE_OFFLINE) o.status = 1'b1;
                else begin
                    car_floor = 1;
                    weight_sum = 0;
                    stopping = 0;
                    going_up = 1;
                    for (int i = 0; i < NS; i++) slots[i] = '0;
                    mode = MODE_IDLE;
                end
            default:
                if (stopping) o.status = 1'b1;
                else stopping = 1;
        endcase
        waiting = 0;
        for (int f = 0; f < NF; f++) waiting += q_count[f];
        o.car_state = mode;
        o.floor_now = car_floor[2:0];
        o.load_weight = weight_sum[7:0];
        o.riders_on_board = 3'(riders_now());
        o.queued_riders = waiting[6:0];
        o.total_served = served;
        o.delay_code = dly;
        return o;
    endfunction

    task automatic compare_field(string name, longint unsigned exp_v, longint unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    initial begin
        fail_count = 0;
        tick_count = 0;
        move_count = 0;
        reject_count = 0;
        lim_riders = 5;
        lim_weight = 50;
        type_weight = '{3, 14, 10, 16};
        for (int f = 0; f < NF; f++) begin
            q_head[f] = 0;
            q_count[f] = 0;
        end
        for (int i = 0; i < NS; i++) slots[i] = '0;
        mode = MODE_OFFLINE;
        car_floor = 1;
        going_up = 1;
        stopping = 0;
        weight_sum = 0;
        served = 0;
    end

    assign pending = expected_words.size();

    always @(posedge clk) begin
        out_word_t exp_w;
        out_word_t new_w;
        if (rst_n) begin
            if (result_valid) begin
                if (expected_words.size() == 0) begin
                    $error("result word with no prediction waiting");
                    fail_count++;
                end
                else begin
                    exp_w = expected_words.pop_front();
                    compare_field("status", exp_w.status, result.status);
                    compare_field("car_state", exp_w.car_state, result.car_state);
                    compare_field("floor_now", exp_w.floor_now, result.floor_now);
                    compare_field("load_weight", exp_w.load_weight, result.load_weight);
                    compare_field("riders_on_board", exp_w.riders_on_board,
                                  result.riders_on_board);
                    compare_field("queued_riders", exp_w.queued_riders, result.queued_riders);
                    compare_field("total_served", exp_w.total_served, result.total_served);
                    compare_field("delay_code", exp_w.delay_code, result.delay_code);
                end
            end
            if (cfg_valid && cfg_ready)
                case (cfg_index_t'(cfg_index))
                    CFG_MAX_RIDERS: lim_riders = cfg_data[2:0];
                    CFG_MAX_WEIGHT: lim_weight = cfg_data;
                    CFG_WEIGHT0:    type_weight[0] = cfg_data[5:0];
                    CFG_WEIGHT1:    type_weight[1] = cfg_data[5:0];
                    CFG_WEIGHT2:    type_weight[2] = cfg_data[5:0];
                    CFG_WEIGHT3:    type_weight[3] = cfg_data[5:0];
                    default: ;
                endcase
            if (start && !busy) begin
                new_w = predict_word(in_word);
                if (in_word.kind == KIND_TICK) tick_count++;
                if (new_w.delay_code == DELAY_MOVE) move_count++;
                if (new_w.status) reject_count++;
                expected_words.push_back(new_w);
            end
        end
    end

endmodule

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// drives ride requests, ticks, start and stop words and register writes into
// the elevator core across several limit settings; the checker judges results
// ----------------------------------------------------------------------------
module testbench;
    import lec_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1_500_000;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    in_word_t   in_word;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [2:0] cfg_index;
    logic [7:0] cfg_data;
    logic       result_valid;
    out_word_t  result;
    int         fail_count;
    int         pending;
    int         tick_count;
    int         move_count;
    int         reject_count;
    int         cycle_count;
    int         idle_pct;
    int         sent;

    look_elevator_controller_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .in_word      (in_word),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result       (result)
    );

    lec_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .in_word      (in_word),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result       (result),
        .fail_count   (fail_count),
        .pending      (pending),
        .tick_count   (tick_count),
        .move_count   (move_count),
        .reject_count (reject_count)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic send_word(kind_t k, int sf, int df, int ty);
        while ($urandom_range(99) < idle_pct) @(posedge clk);
        start <= 1'b1;
        in_word <= '{kind: k, start_floor: sf[2:0], target_floor: df[2:0],
                     rider_type: ty[2:0]};
        do @(posedge clk); while (busy);
        start <= 1'b0;
        @(posedge clk);
        sent++;
    endtask

    task automatic write_reg(cfg_index_t idx, int val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[7:0];
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain_and_pause();
        while (pending != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic set_limits(int riders, int weight, int w0, int w1, int w2, int w3);
        drain_and_pause();
        write_reg(CFG_MAX_RIDERS, riders);
        write_reg(CFG_MAX_WEIGHT, weight);
        write_reg(CFG_WEIGHT0, w0);
        write_reg(CFG_WEIGHT1, w1);
        write_reg(CFG_WEIGHT2, w2);
        write_reg(CFG_WEIGHT3, w3);
    endtask

    // mostly valid requests and ticks, some malformed and start/stop words
    task automatic random_run(int count);
        int r;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(99);
            if (n % 500 < 167) idle_pct = 31;
            else if (n % 500 < 334) idle_pct = 51;
            else idle_pct = 0;
            if (r < 50)
                send_word(KIND_TICK, $urandom_range(7), $urandom_range(7), $urandom_range(7));
            else if (r < 82)
                send_word(KIND_RIDE, $urandom_range(1, 5), $urandom_range(1, 5),
                          $urandom_range(3));
            else if (r < 90)
                send_word(KIND_RIDE, $urandom_range(7), $urandom_range(7), $urandom_range(7));
            else if (r < 96)
                send_word(KIND_START, $urandom_range(7), $urandom_range(7), $urandom_range(7));
            else
                send_word(KIND_STOP, $urandom_range(7), $urandom_range(7), $urandom_range(7));
        end
    endtask

    initial begin
        rst_n = 1'b0;
        start = 1'b0;
        in_word = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_MAX_RIDERS;
        cfg_data = '0;
        cycle_count = 0;
        idle_pct = 0;
        sent = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: offline tick, bad requests, full queue, start/stop cases
        send_word(KIND_TICK, 0, 0, 0);
        send_word(KIND_RIDE, 0, 3, 0);
        send_word(KIND_RIDE, 6, 3, 0);
        send_word(KIND_RIDE, 2, 7, 1);
        send_word(KIND_RIDE, 3, 3, 2);
        send_word(KIND_RIDE, 1, 5, 4);
        send_word(KIND_RIDE, 5, 1, 3);
        send_word(KIND_STOP, 0, 0, 0);
        send_word(KIND_STOP, 0, 0, 0);
        send_word(KIND_START, 0, 0, 0);
        send_word(KIND_START, 0, 0, 0);
        for (int i = 0; i < 17; i++) send_word(KIND_RIDE, 2, 1 + (i % 4 == 0 ? 3 : 4), i % 4);
        for (int i = 0; i < 40; i++) send_word(KIND_TICK, 7, 7, 7);
        send_word(KIND_STOP, 0, 0, 0);
        for (int i = 0; i < 30; i++) send_word(KIND_TICK, 0, 0, 0);

        random_run(450);
        set_limits(0, 255, 63, 63, 63, 63);
        send_word(KIND_START, 0, 0, 0);
        random_run(200);
        set_limits(1, 0, 0, 0, 0, 0);
        random_run(200);
        set_limits(5, 255, 0, 63, 1, 40);
        random_run(350);
        set_limits(3, 20, 5, 9, 20, 21);
        random_run(250);

        while (pending != 0) @(posedge clk);
        repeat (60) @(posedge clk);
        $display("%0d words sent, %0d ticks, %0d moves, %0d rejects", sent, tick_count,
                 move_count, reject_count);
        $display("limits covered: riders 0..5, weight 0..255, weights 0..63");
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
